FILE: rtl/core/ps2mpt_pkg.sv
// shared types, header bit positions and movement helpers for the ps2 mouse packet tracker
package ps2mpt_pkg;

   localparam int unsigned POS_WIDTH  = 32;
   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned STEP_WIDTH = 10;

   localparam int unsigned HDR_LEFT_BIT  = 0;
   localparam int unsigned HDR_RIGHT_BIT = 1;
   localparam int unsigned HDR_VALID_BIT = 3;
   localparam int unsigned HDR_XSIGN_BIT = 4;
   localparam int unsigned HDR_YSIGN_BIT = 5;
   localparam int unsigned HDR_XOVF_BIT  = 6;
   localparam int unsigned HDR_YOVF_BIT  = 7;

   localparam logic signed [STEP_WIDTH-1:0] OVF_STEP = STEP_WIDTH'(255);

   typedef enum logic [2:0] {
      PHASE_HEADER = 3'b001,
      PHASE_XDATA  = 3'b010,
      PHASE_YDATA  = 3'b100
   } phase_type;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] x_position;
      logic signed [POS_WIDTH-1:0] y_position;
      logic                        left_button;
      logic                        right_button;
   } result_type;

   // signed movement: +byte, or -((256-byte) mod 256), plus or minus 255 on overflow
   function automatic logic signed [STEP_WIDTH-1:0] move_step(
      input logic [BYTE_WIDTH-1:0] data,
      input logic                  sign,
      input logic                  ovf
   );
      logic signed [STEP_WIDTH-1:0] base;
      logic signed [STEP_WIDTH-1:0] extra;
      if (!sign) begin
         base  = {2'b00, data};
         extra = OVF_STEP;
      end else begin
         base  = (data == '0) ? '0 : {2'b11, data};
         extra = -OVF_STEP;
      end
      move_step = ovf ? base + extra : base;
   endfunction

endpackage

FILE: rtl/core/ps2mpt_req_if.sv
// request channel carrying one received mouse byte
interface ps2mpt_req_if
   import ps2mpt_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/ps2mpt_rsp_if.sv
// response channel carrying one decoded packet result
interface ps2mpt_rsp_if
   import ps2mpt_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic signed [POS_WIDTH-1:0] x_position;
   logic signed [POS_WIDTH-1:0] y_position;
   logic                        left_button;
   logic                        right_button;

   modport source (output valid, output x_position, output y_position,
                   output left_button, output right_button, input ready);
   modport sink   (input valid, input x_position, input y_position,
                   input left_button, input right_button, output ready);
endinterface

FILE: rtl/core/ps2mpt_input_stage.sv
// input register holding one received byte until the framer takes it
module ps2mpt_input_stage
   import ps2mpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ps2mpt_req_if.sink            req_bus,
   input  logic                  item_take,
   output logic                  item_valid,
   output logic [BYTE_WIDTH-1:0] item_byte
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [BYTE_WIDTH-1:0] byte_ff;
   logic                  transfer;

   assign req_bus.ready = !valid_ff || item_take;
   assign transfer      = req_bus.valid && req_bus.ready;

   always_comb begin
      if (transfer) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (transfer) begin
         byte_ff <= req_bus.rx_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

FILE: rtl/core/ps2mpt_framer.sv
// packet framing, movement decode and position accumulators
module ps2mpt_framer
   import ps2mpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  logic [BYTE_WIDTH-1:0] item_byte,
   input  logic                  out_free,
   output logic                  item_take,
   output logic                  result_load,
   output result_type            result
);

   phase_type                    phase_ff;
   phase_type                    phase_in;
   logic [BYTE_WIDTH-1:0]        header_ff;
   logic [BYTE_WIDTH-1:0]        header_in;
   logic [BYTE_WIDTH-1:0]        xdata_ff;
   logic [BYTE_WIDTH-1:0]        xdata_in;
   logic signed [POS_WIDTH-1:0]  x_accum_ff;
   logic signed [POS_WIDTH-1:0]  x_accum_in;
   logic signed [POS_WIDTH-1:0]  y_accum_ff;
   logic signed [POS_WIDTH-1:0]  y_accum_in;
   logic signed [STEP_WIDTH-1:0] x_step;
   logic signed [STEP_WIDTH-1:0] y_step;
   logic                         need_slot;

   assign need_slot   = (phase_ff == PHASE_YDATA);
   assign item_take   = item_valid && (!need_slot || out_free);
   assign result_load = item_take && need_slot;

   assign x_step = move_step(xdata_ff, header_ff[HDR_XSIGN_BIT], header_ff[HDR_XOVF_BIT]);
   assign y_step = move_step(item_byte, header_ff[HDR_YSIGN_BIT], header_ff[HDR_YOVF_BIT]);

   always_comb begin
      phase_in   = phase_ff;
      header_in  = header_ff;
      xdata_in   = xdata_ff;
      x_accum_in = x_accum_ff;
      y_accum_in = y_accum_ff;
      if (item_take) begin
         case (phase_ff)
            PHASE_XDATA: begin
               xdata_in = item_byte;
               phase_in = PHASE_YDATA;
            end
            PHASE_YDATA: begin
               x_accum_in = x_accum_ff + POS_WIDTH'(x_step);
               y_accum_in = y_accum_ff - POS_WIDTH'(y_step);
               phase_in   = PHASE_HEADER;
            end
            default: begin
               if (item_byte[HDR_VALID_BIT]) begin
                  header_in = item_byte;
                  phase_in  = PHASE_XDATA;
               end else begin
                  phase_in = PHASE_HEADER;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_HEADER;
         header_ff  <= '0;
         xdata_ff   <= '0;
         x_accum_ff <= '0;
         y_accum_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         header_ff  <= header_in;
         xdata_ff   <= xdata_in;
         x_accum_ff <= x_accum_in;
         y_accum_ff <= y_accum_in;
      end
   end

   assign result.x_position   = x_accum_in;
   assign result.y_position   = y_accum_in;
   assign result.left_button  = header_ff[HDR_LEFT_BIT];
   assign result.right_button = header_ff[HDR_RIGHT_BIT];

endmodule

FILE: rtl/core/ps2mpt_result_stage.sv
// output register holding one packet result until the consumer takes it
module ps2mpt_result_stage
   import ps2mpt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         result_load,
   input  result_type   result,
   output logic         out_free,
   ps2mpt_rsp_if.source rsp_bus
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign out_free = !valid_ff || rsp_bus.ready;

   always_comb begin
      if (result_load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         result_ff <= result;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.x_position   = result_ff.x_position;
   assign rsp_bus.y_position   = result_ff.y_position;
   assign rsp_bus.left_button  = result_ff.left_button;
   assign rsp_bus.right_button = result_ff.right_button;

endmodule

FILE: rtl/core/ps2mpt_pkg_top_note.sv
// framer wrapper joining the input register, the framer and the result register
module ps2mpt_core
   import ps2mpt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ps2mpt_req_if.sink   req_bus,
   ps2mpt_rsp_if.source rsp_bus
);

   logic                  item_valid;
   logic [BYTE_WIDTH-1:0] item_byte;
   logic                  item_take;
   logic                  result_load;
   logic                  out_free;
   result_type            result;

   ps2mpt_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .item_take  (item_take),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   ps2mpt_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item_byte   (item_byte),
      .out_free    (out_free),
      .item_take   (item_take),
      .result_load (result_load),
      .result      (result)
   );

   ps2mpt_result_stage u_result (
      .clock       (clock),
      .reset       (reset),
      .result_load (result_load),
      .result      (result),
      .out_free    (out_free),
      .rsp_bus     (rsp_bus)
   );

endmodule

FILE: rtl/core/ps2_mouse_packet_tracker_top.sv
// top level of the ps2 mouse packet tracker
//
//   channel   role     payload
//   req_bus   sink     rx_byte (8 bits, one mouse byte)
//   rsp_bus   source   x_position, y_position (32 bits signed), left_button, right_button
//
// one byte per cycle while the result register does not stall the third byte; a
// byte passes the input register and the framer logic and lands in the result
// register, which loads a result when the framer takes its third byte
// reset (synchronous, active high) clears phase, header, x byte and both positions
// only the third byte of a packet waits on a free result register; header and
// x bytes keep flowing while a result stalls
module ps2_mouse_packet_tracker_top
   import ps2mpt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ps2mpt_req_if.sink   req_bus,
   ps2mpt_rsp_if.source rsp_bus
);

   ps2mpt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule
